FILE: rtl/rfatc_pkg.sv
// ----------------------------------------------------------------------------
// rfatc_pkg: shared types and constants
// Status codes, reading kinds, register indexes and field widths for the
// rangefinder averaging and tilt correction block.
// ----------------------------------------------------------------------------
`default_nettype none

package rfatc_pkg;

    // default sizes
    localparam int FILTER_DEPTH_DEF  = 5;
    localparam int DISTANCE_BITS_DEF = 16;

    // field widths
    localparam int DIST_W   = 16;
    localparam int COS_W    = 16;
    localparam int TILT_W   = 15;
    localparam int TIME_W   = 32;
    localparam int TMO_W    = 16;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // reading status codes
    localparam logic [STATUS_W-1:0] ST_VALID     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OOR       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NO_DATA   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_SENSOR = 3'd4;

    // raw reading kinds
    localparam logic [KIND_W-1:0] KIND_VALID = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OOR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TILT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

    // register reset values
    localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd500;

endpackage

`default_nettype wire

FILE: rtl/rfatc_avg.sv
// ----------------------------------------------------------------------------
// rfatc_avg: ring averager
// Holds the sample ring, sums all slots one per cycle and divides the sum by
// the fill count with a restoring divider, one quotient bit per cycle. The
// sum and the divide share one add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module rfatc_avg #(
    parameter int FILTER_DEPTH = rfatc_pkg::FILTER_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push,
    input  wire logic [rfatc_pkg::DIST_W-1:0] i_sample,
    output logic                             o_done,
    output logic [rfatc_pkg::DIST_W-1:0]     o_avg
);
    import rfatc_pkg::*;

    localparam int SLOT_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int CNT_W  = $clog2(FILTER_DEPTH + 1);
    localparam int SUM_W  = DIST_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FILTER_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL      = CNT_W'(FILTER_DEPTH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    typedef enum logic [1:0] {A_IDLE, A_SUM, A_DIV} t_avg_state;

    t_avg_state          r_state;
    logic [DIST_W-1:0]   r_ring [FILTER_DEPTH];
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_idx;
    logic [CNT_W-1:0]    r_fill;
    logic [SUM_W-1:0]    r_acc;
    logic [CNT_W-1:0]    r_rem;
    logic [SUM_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_step;
    logic                r_done;

    logic                alu_sub;
    logic [SUM_W-1:0]    alu_a;
    logic [SUM_W-1:0]    alu_b;
    logic [SUM_W:0]      alu_y;
    logic [CNT_W:0]      rem_sh;
    logic                ge;

    // shared add/subtract unit: accumulate in sum, trial subtract in divide
    assign rem_sh  = {r_rem, r_quo[SUM_W-1]};
    assign alu_sub = (r_state == A_DIV);
    always_comb begin
        alu_a = alu_sub ? SUM_W'(rem_sh) : r_acc;
        alu_b = alu_sub ? SUM_W'(r_fill) : SUM_W'(r_ring[r_idx]);
        if (alu_sub) begin
            alu_y = {1'b0, alu_a} - {1'b0, alu_b};
        end else begin
            alu_y = {1'b0, alu_a} + {1'b0, alu_b};
        end
    end
    assign ge = ~alu_y[SUM_W];

    // sequencer, ring and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_slot  <= '0;
            r_idx   <= '0;
            r_fill  <= '0;
            r_done  <= 1'b0;
            for (int k = 0; k < FILTER_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_push) begin
                        r_ring[r_slot] <= i_sample;
                        r_slot  <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
                        if (r_fill != FULL) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_idx   <= '0;
                        r_state <= A_SUM;
                    end
                end
                A_SUM: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_SLOT) begin
                        r_state <= A_DIV;
                    end
                end
                A_DIV: begin
                    if (r_step == LAST_STEP) begin
                        r_state <= A_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    // datapath words
    always_ff @(posedge i_clk) begin
        if (r_state == A_IDLE) begin
            r_acc <= '0;
        end else if (r_state == A_SUM) begin
            r_acc <= alu_y[SUM_W-1:0];
            if (r_idx == LAST_SLOT) begin
                r_quo  <= alu_y[SUM_W-1:0];
                r_rem  <= '0;
                r_step <= '0;
            end
        end else begin
            r_quo  <= {r_quo[SUM_W-2:0], ge};
            r_rem  <= ge ? alu_y[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_step <= r_step + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_avg  = r_quo[DIST_W-1:0];

    // checks
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == A_DIV) |-> (r_fill != '0))
        else $error("divide started with empty ring");
    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_state == A_IDLE))
        else $error("sample pushed while averager busy");
    a_done_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(r_state) == A_DIV))
        else $error("done without a divide");

endmodule

`default_nettype wire

FILE: rtl/rangefinder_average_tilt_correct.sv
// ----------------------------------------------------------------------------
// rangefinder_average_tilt_correct: rangefinder reading processor
// Optional ring average of valid distances, tilt correction of the raw
// distance and a response timeout health flag, one result word per reading.
// ----------------------------------------------------------------------------
//  channel   signals                          direction   word
//  input     i_in_valid / o_in_ready          in          status, distance, tilt, time
//  output    o_out_valid / i_out_ready        out         updated, raw, altitude, healthy
//  config    i_cfg_valid / o_cfg_ready        in          register index and data
//
//  a valid reading with the averager on goes through the ring sum, one ring
//  slot summed per cycle, then one quotient bit per cycle from the shared
//  add/subtract unit of the averager, then multiply and result register.
//  other readings go through multiply, then result register; no new data
//  goes straight to the result register.
//  o_in_ready is high only while the sequencer is idle; a result waiting on
//  i_out_ready does not block the next word, only its final write-back.
//  synchronous reset clears the ring and the held readings and returns the registers to their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module rangefinder_average_tilt_correct #(
    parameter int FILTER_DEPTH  = rfatc_pkg::FILTER_DEPTH_DEF,
    parameter int DISTANCE_BITS = rfatc_pkg::DISTANCE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rfatc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rfatc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // readings
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [rfatc_pkg::STATUS_W-1:0]   i_reading_status,
    input  wire logic [rfatc_pkg::DIST_W-1:0]     i_distance_cm,
    input  wire logic signed [rfatc_pkg::COS_W-1:0] i_tilt_cos,
    input  wire logic [rfatc_pkg::TIME_W-1:0]     i_now_ms,
    // results
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_updated,
    output logic [rfatc_pkg::KIND_W-1:0]          o_raw_state,
    output logic [rfatc_pkg::DIST_W-1:0]          o_raw_distance,
    output logic                                 o_altitude_valid,
    output logic [rfatc_pkg::DIST_W-1:0]          o_altitude_cm,
    output logic                                 o_healthy
);
    import rfatc_pkg::*;

    localparam logic [31:0] DIST_MAX  = (32'd1 << DISTANCE_BITS) - 32'd1;
    localparam logic [DIST_W-1:0] DIST_MASK = DIST_MAX[DIST_W-1:0];
    localparam int PROD_W = DIST_W + TILT_W;
    localparam int SHR_W  = PROD_W - 14;

    typedef enum logic [1:0] {S_IDLE, S_AVG, S_MUL, S_FIN} t_state;

    t_state              r_state;
    logic                r_filter_en;
    logic [TILT_W-1:0]   r_max_tilt;
    logic [TMO_W-1:0]    r_timeout;
    logic [KIND_W-1:0]   r_raw_kind;
    logic [DIST_W-1:0]   r_raw_value;
    logic                r_alt_ok;
    logic [DIST_W-1:0]   r_alt_value;
    logic [TIME_W-1:0]   r_last_resp;
    logic                r_upd;
    logic                r_out_valid;
    logic [TIME_W-1:0]   r_now;
    logic signed [COS_W-1:0] r_cos;
    logic [PROD_W-1:0]   r_prod;
    logic                r_alt_en;
    logic                r_o_updated;
    logic [KIND_W-1:0]   r_o_raw_state;
    logic [DIST_W-1:0]   r_o_raw_distance;
    logic                r_o_alt_valid;
    logic [DIST_W-1:0]   r_o_alt_cm;
    logic                r_o_healthy;

    logic                in_acc;
    logic                out_free;
    logic                avg_push;
    logic                avg_done;
    logic [DIST_W-1:0]   avg_value;
    logic [DIST_W-1:0]   dist_m;
    logic                tilt_ok;
    logic [SHR_W-1:0]    prod_sh;
    logic [DIST_W-1:0]   sat_val;
    logic                n_alt_ok;
    logic [DIST_W-1:0]   n_alt_value;
    logic [TIME_W-1:0]   age;
    logic                healthy;

    assign in_acc      = i_in_valid & o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = ~r_out_valid | i_out_ready;
    assign dist_m      = i_distance_cm & DIST_MASK;
    assign avg_push    = in_acc & (i_reading_status == ST_VALID) & r_filter_en;

    // ring averager
    rfatc_avg #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_avg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (avg_push),
        .i_sample (dist_m),
        .o_done   (avg_done),
        .o_avg    (avg_value)
    );

    // tilt limit and saturated altitude
    assign tilt_ok = ~(r_cos < $signed({1'b0, r_max_tilt}));
    assign prod_sh = r_prod[PROD_W-1:14];
    assign sat_val = ({{(32-SHR_W){1'b0}}, prod_sh} > DIST_MAX) ? DIST_MAX[DIST_W-1:0]
                                                             : prod_sh[DIST_W-1:0];
    always_comb begin
        n_alt_ok    = r_alt_ok;
        n_alt_value = r_alt_value;
        if (r_upd) begin
            n_alt_ok    = r_alt_en;
            n_alt_value = r_alt_en ? sat_val : '0;
        end
    end

    // health from elapsed time
    assign age     = r_now - r_last_resp;
    assign healthy = (age < {{(TIME_W-TMO_W){1'b0}}, r_timeout});

    // sequencer, held readings and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filter_en <= 1'b0;
            r_max_tilt  <= '0;
            r_timeout   <= TIMEOUT_RST;
            r_raw_kind  <= KIND_OOR;
            r_raw_value <= '0;
            r_alt_ok    <= 1'b0;
            r_alt_value <= '0;
            r_last_resp <= '0;
            r_upd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FILTER_EN: r_filter_en <= i_cfg_data[0];
                    CFG_MAX_TILT:  r_max_tilt  <= i_cfg_data[TILT_W-1:0];
                    CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TMO_W-1:0];
                    default:       ;
                endcase
            end

            // result word taken, unless a new one is loaded this cycle
            if (r_out_valid && i_out_ready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_upd <= (i_reading_status != ST_NO_DATA);
                        case (i_reading_status)
                            ST_NO_DATA: begin
                                r_state <= S_FIN;
                            end
                            ST_VALID: begin
                                r_last_resp <= i_now_ms;
                                r_raw_kind  <= KIND_VALID;
                                if (r_filter_en) begin
                                    r_state <= S_AVG;
                                end else begin
                                    r_raw_value <= dist_m;
                                    r_state     <= S_MUL;
                                end
                            end
                            ST_OOR: begin
                                r_last_resp <= i_now_ms;
                                r_raw_kind  <= KIND_OOR;
                                r_raw_value <= '0;
                                r_state     <= S_MUL;
                            end
                            ST_NO_SENSOR: begin
                                r_raw_kind  <= KIND_OOR;
                                r_raw_value <= '0;
                                r_state     <= S_MUL;
                            end
                            default: begin
                                r_raw_kind  <= KIND_FAIL;
                                r_raw_value <= '0;
                                r_state     <= S_MUL;
                            end
                        endcase
                    end
                end
                S_AVG: begin
                    if (avg_done) begin
                        r_raw_value <= avg_value;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_alt_ok    <= n_alt_ok;
                        r_alt_value <= n_alt_value;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload: reading capture, product and result word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_now <= i_now_ms;
            r_cos <= i_tilt_cos;
        end
        if (r_state == S_MUL) begin
            r_prod   <= PROD_W'(r_raw_value) * PROD_W'(r_cos[TILT_W-1:0]);
            r_alt_en <= tilt_ok & (r_raw_kind == KIND_VALID);
        end
        if (r_state == S_FIN && out_free) begin
            r_o_updated      <= r_upd;
            r_o_raw_state    <= r_raw_kind;
            r_o_raw_distance <= r_raw_value;
            r_o_alt_valid    <= n_alt_ok;
            r_o_alt_cm       <= n_alt_value;
            r_o_healthy      <= healthy;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_updated        = r_o_updated;
    assign o_raw_state      = r_o_raw_state;
    assign o_raw_distance   = r_o_raw_distance;
    assign o_altitude_valid = r_o_alt_valid;
    assign o_altitude_cm    = r_o_alt_cm;
    assign o_healthy        = r_o_healthy;

    // checks
    a_avg_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        avg_done |-> (r_state == S_AVG))
        else $error("average finished outside its wait state");
    a_filter_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        avg_push |=> (r_state == S_AVG))
        else $error("filtered reading skipped the averager");
    a_alt_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && r_alt_ok) |-> (r_raw_kind == KIND_VALID))
        else $error("altitude usable without a valid raw reading");
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result word loaded outside the final state");

endmodule

`default_nettype wire

FILE: sim/tb_rangefinder_average_tilt_correct.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rangefinder_average_tilt_correct: self-checking bench for the reading processor
// Directed words cover every status code, tilt and timeout extremes and the
// averager. Random phases follow, each with new register settings and its own
// sender and receiver idling. Every result word is checked against an
// in-bench model of the averager, tilt correction and health flag.
// ----------------------------------------------------------------------------

module tb_rangefinder_average_tilt_correct;

    import rfatc_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_WAIT  = 40;       // longer than the averaging path
    localparam int RUN_LIMIT    = 500000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_WORDS  = 106;
    localparam int SLOTS        = FILTER_DEPTH_DEF;
    localparam int DIST_TOP     = (1 << DISTANCE_BITS_DEF) - 1;
    localparam logic [COS_W-1:0] COS_ONE = 16'd16384;   // 1.0 in Q2.14
    localparam logic [COS_W-1:0] COS_MIN = 16'h8000;    // most negative cosine
    localparam logic [COS_W-1:0] COS_TOP = 16'h7FFF;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // idling profiles
    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } t_idle_mode;

    typedef struct packed {
        logic              updated;
        logic [KIND_W-1:0] raw_state;
        logic [DIST_W-1:0] raw_distance;
        logic              altitude_valid;
        logic [DIST_W-1:0] altitude_cm;
        logic              healthy;
    } t_reading_result;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [STATUS_W-1:0]           i_reading_status = '0;
    logic [DIST_W-1:0]             i_distance_cm = '0;
    logic signed [COS_W-1:0]       i_tilt_cos = '0;
    logic [TIME_W-1:0]             i_now_ms = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b1;
    logic                          o_updated;
    logic [KIND_W-1:0]             o_raw_state;
    logic [DIST_W-1:0]             o_raw_distance;
    logic                          o_altitude_valid;
    logic [DIST_W-1:0]             o_altitude_cm;
    logic                          o_healthy;

    // model state and register copies
    logic [DIST_W-1:0]   avg_ring [SLOTS];
    int                  avg_slot = 0;
    int                  avg_fill = 0;
    logic [KIND_W-1:0]   held_kind = KIND_OOR;
    logic [DIST_W-1:0]   held_distance = '0;
    logic                held_alt_ok = 1'b0;
    logic [DIST_W-1:0]   held_altitude = '0;
    logic [TIME_W-1:0]   last_response = '0;
    logic                reg_filter_en = 1'b0;
    logic [TILT_W-1:0]   reg_max_tilt = '0;
    logic [TMO_W-1:0]    reg_timeout = TIMEOUT_RST;

    t_reading_result     expected_results [$];
    int                  error_count = 0;
    int                  cycle_count = 0;
    int                  in_idle_pct = 0;
    int                  out_stall_pct = 0;
    logic [TIME_W-1:0]   clock_ms = '0;

    rangefinder_average_tilt_correct dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_reading_status (i_reading_status),
        .i_distance_cm    (i_distance_cm),
        .i_tilt_cos       (i_tilt_cos),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_updated        (o_updated),
        .o_raw_state      (o_raw_state),
        .o_raw_distance   (o_raw_distance),
        .o_altitude_valid (o_altitude_valid),
        .o_altitude_cm    (o_altitude_cm),
        .o_healthy        (o_healthy)
    );

    // clock
    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("FAIL rangefinder_average_tilt_correct");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    initial begin
        foreach (avg_ring[k]) avg_ring[k] = '0;
    end

    // register write into the model copy
    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FILTER_EN: reg_filter_en = data[0];
            CFG_MAX_TILT:  reg_max_tilt  = data[TILT_W-1:0];
            CFG_TIMEOUT:   reg_timeout   = data[TMO_W-1:0];
            default: ;
        endcase
    endtask

    // averager push: sum of every slot over the fill count, truncated
    task automatic average_distance(input logic [DIST_W-1:0] dist_cm,
                                    output logic [DIST_W-1:0] avg);
        int unsigned sum;
        int unsigned quot;
        avg_ring[avg_slot] = dist_cm;
        avg_slot = (avg_slot == SLOTS - 1) ? 0 : avg_slot + 1;
        if (avg_fill < SLOTS) avg_fill++;
        sum = 0;
        for (int k = 0; k < SLOTS; k++) sum += 32'(avg_ring[k]);
        quot = sum / avg_fill;
        if (quot > DIST_TOP) quot = DIST_TOP;
        avg = quot[DIST_W-1:0];
    endtask

    // next result word for one accepted reading
    task automatic predict_reading(input logic [STATUS_W-1:0] status,
                                   input logic [DIST_W-1:0] dist_cm,
                                   input logic signed [COS_W-1:0] cos_q14,
                                   input logic [TIME_W-1:0] now);
        t_reading_result r;
        int              cos_int;
        longint          prod;
        logic [TIME_W-1:0] age;
        cos_int = int'(cos_q14);
        r.updated = (status != ST_NO_DATA);
        if (status != ST_NO_DATA) begin
            if (status == ST_VALID) begin
                last_response = now;
                held_kind = KIND_VALID;
                if (reg_filter_en) average_distance(dist_cm, held_distance);
                else held_distance = dist_cm;
            end else if (status == ST_OOR || status == ST_NO_SENSOR) begin
                // no sensor leaves the response time alone
                if (status == ST_OOR) last_response = now;
                held_kind = KIND_OOR;
                held_distance = '0;
            end else begin
                // hardware failure and unknown codes
                held_kind = KIND_FAIL;
                held_distance = '0;
            end
            if (cos_int < int'(reg_max_tilt) || held_kind != KIND_VALID) begin
                held_alt_ok = 1'b0;
                held_altitude = '0;
            end else begin
                prod = (longint'(held_distance) * longint'(cos_int)) >>> 14;
                if (prod > DIST_TOP) prod = DIST_TOP;
                held_alt_ok = 1'b1;
                held_altitude = prod[DIST_W-1:0];
            end
        end
        age = now - last_response;
        r.raw_state      = held_kind;
        r.raw_distance   = held_distance;
        r.altitude_valid = held_alt_ok;
        r.altitude_cm    = held_altitude;
        r.healthy        = (age < {16'd0, reg_timeout});
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // watch handshakes: registers, readings in, result words out
    always @(posedge i_clk) begin : word_monitor
        t_reading_result got;
        t_reading_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_updated, o_raw_state, o_raw_distance,
                        o_altitude_valid, o_altitude_cm, o_healthy};
                if (expected_results.size() == 0) begin
                    $error("result word with no reading pending");
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("updated", 32'(want.updated), 32'(got.updated));
                    check_field("raw_state", 32'(want.raw_state), 32'(got.raw_state));
                    check_field("raw_distance", 32'(want.raw_distance),
                                32'(got.raw_distance));
                    check_field("altitude_valid", 32'(want.altitude_valid),
                                32'(got.altitude_valid));
                    check_field("altitude_cm", 32'(want.altitude_cm),
                                32'(got.altitude_cm));
                    check_field("healthy", 32'(want.healthy), 32'(got.healthy));
                end
            end
            if (i_cfg_valid && o_cfg_ready) apply_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                predict_reading(i_reading_status, i_distance_cm, i_tilt_cos, i_now_ms);
        end
    end

    // send one reading word, holding it until accepted
    task automatic send_reading(input logic [STATUS_W-1:0] status,
                                input logic [DIST_W-1:0] dist_cm,
                                input logic [COS_W-1:0] cos_bits,
                                input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_reading_status <= status;
        i_distance_cm    <= dist_cm;
        i_tilt_cos       <= cos_bits;
        i_now_ms         <= now;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // drop valid, wait for every pending result and let the block go idle
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:     begin in_idle_pct = 0;  out_stall_pct = 0;  end
            IDLE_SENDER:   begin in_idle_pct = 71; out_stall_pct = 0;  end
            IDLE_RECEIVER: begin in_idle_pct = 0;  out_stall_pct = 71; end
            default:       begin in_idle_pct = 24; out_stall_pct = 24; end
        endcase
    endtask

    // held reset state and the default timeout edge
    task automatic test_reset_state();
        send_reading(ST_NO_DATA, 16'hFFFF, 16'd0, 32'd0);
        send_reading(ST_NO_DATA, 16'd0, COS_ONE, 32'd499);
        send_reading(ST_NO_DATA, 16'd0, COS_ONE, 32'd500);
    endtask

    // every status code with distance and cosine extremes
    task automatic test_status_codes();
        send_reading(ST_VALID, 16'hFFFF, COS_ONE, 32'd1000);
        send_reading(ST_VALID, 16'hFFFF, COS_TOP, 32'd1001);   // saturates
        send_reading(ST_VALID, 16'd0, COS_MIN, 32'd1002);      // negative tilt
        send_reading(ST_OOR, 16'd1234, COS_ONE, 32'd1003);
        send_reading(ST_FAIL, 16'hFFFF, COS_ONE, 32'd1004);
        send_reading(ST_NO_SENSOR, 16'd50, COS_ONE, 32'd1600);
        send_reading(ST_NO_DATA, 16'd77, COS_ONE, 32'd1200);
        send_reading(3'd5, 16'd10, COS_ONE, 32'd1300);
        send_reading(3'd7, 16'd10, COS_ONE, 32'd1400);
    endtask

    // tilt limit at 1.0 and at the top of the field
    task automatic test_tilt_limit();
        settle();
        write_register(CFG_MAX_TILT, 16'd16384);
        send_reading(ST_VALID, 16'd3000, 16'd16383, 32'd2000);
        send_reading(ST_VALID, 16'd3000, COS_ONE, 32'd2001);
        settle();
        write_register(CFG_MAX_TILT, 16'hFFFF);                // upper bit dropped
        send_reading(ST_VALID, 16'd40000, COS_TOP, 32'd2002);
        send_reading(ST_VALID, 16'd40000, 16'h7FFE, 32'd2003);
        settle();
        write_register(CFG_MAX_TILT, 16'd0);
    endtask

    // ring averager fill and hold while disabled
    task automatic test_averager();
        settle();
        write_register(CFG_FILTER_EN, 16'd1);
        send_reading(ST_VALID, 16'hFFFF, COS_ONE, 32'd3000);
        send_reading(ST_VALID, 16'hFFFF, 16'd12000, 32'd3001);
        send_reading(ST_VALID, 16'd100, COS_ONE, 32'd3002);
        settle();
        write_register(CFG_FILTER_EN, 16'd0);
        send_reading(ST_VALID, 16'd7, COS_ONE, 32'd3003);
        settle();
        write_register(CFG_FILTER_EN, 16'hFFFE);               // only bit 0 counts
        write_register(CFG_FILTER_EN, 16'd1);
        send_reading(ST_VALID, 16'd3, COS_ONE, 32'd3004);
    endtask

    // zero and largest timeout, time wrapping past zero
    task automatic test_health_timeout();
        settle();
        write_register(CFG_TIMEOUT, 16'd0);
        send_reading(ST_VALID, 16'd500, COS_ONE, 32'd4000);
        settle();
        write_register(CFG_TIMEOUT, 16'hFFFF);
        send_reading(ST_OOR, 16'd0, COS_ONE, 32'hFFFF_FFF0);
        send_reading(ST_NO_DATA, 16'd0, COS_ONE, 32'h0000_0010);
    endtask

    // write to the spare index has no effect
    task automatic test_spare_register();
        settle();
        write_register(CFG_SPARE, 16'hFFFF);
        send_reading(ST_VALID, 16'd1500, COS_ONE, 32'h0000_0020);
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] tilt;
        logic [CFG_DATA_W-1:0] tmo;
        case ($urandom_range(3))
            0:       tilt = 16'd0;
            1:       tilt = 16'd16384;
            2:       tilt = 16'($urandom_range(0, 16384));
            default: tilt = {1'($urandom_range(1)), 15'($urandom_range(0, 32767))};
        endcase
        case ($urandom_range(5))
            0:       tmo = TIMEOUT_RST;
            1:       tmo = 16'($urandom_range(1, 65535));
            2:       tmo = 16'hFFFF;
            3:       tmo = 16'd0;
            default: tmo = 16'($urandom_range(1, 2000));
        endcase
        write_register(CFG_FILTER_EN, 16'($urandom_range(1)));
        write_register(CFG_MAX_TILT, tilt);
        write_register(CFG_TIMEOUT, tmo);
    endtask

    task automatic random_reading();
        logic [STATUS_W-1:0] status;
        logic [DIST_W-1:0]   dist_cm;
        logic [COS_W-1:0]    cos_bits;
        int                  pick;
        int                  near;
        pick = $urandom_range(99);
        if (pick < 50)      status = ST_VALID;
        else if (pick < 62) status = ST_OOR;
        else if (pick < 70) status = ST_FAIL;
        else if (pick < 80) status = ST_NO_DATA;
        else if (pick < 88) status = ST_NO_SENSOR;
        else                status = 3'($urandom_range(5, 7));
        pick = $urandom_range(99);
        if (pick < 40)      dist_cm = 16'($urandom_range(0, 65535));
        else if (pick < 70) dist_cm = 16'($urandom_range(0, 400));
        else if (pick < 85) dist_cm = 16'hFFFF - 16'($urandom_range(0, 300));
        else                dist_cm = $urandom_range(1) ? 16'hFFFF : 16'd0;
        pick = $urandom_range(99);
        near = int'(reg_max_tilt) + $urandom_range(0, 2) - 1;
        if (pick < 60)      cos_bits = 16'($urandom_range(0, 32768) - 16384);
        else if (pick < 80) cos_bits = near[COS_W-1:0];
        else                cos_bits = 16'($urandom_range(0, 65535));
        // time mostly moves forward in small steps
        pick = $urandom_range(99);
        if (pick < 85)      clock_ms = clock_ms + $urandom_range(0, 1200);
        else if (pick < 95) clock_ms = clock_ms + $urandom_range(0, 70000);
        else                clock_ms = $urandom();
        send_reading(status, dist_cm, cos_bits, clock_ms);
    endtask

    // random phases, each with fresh registers and an idling profile
    task automatic test_random();
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            set_idling(t_idle_mode'(p % 4));
            random_config();
            repeat (PHASE_WORDS) random_reading();
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(IDLE_NONE);
        test_reset_state();
        test_status_codes();
        test_tilt_limit();
        test_averager();
        test_health_timeout();
        test_spare_register();
        test_random();
        settle();
        if (error_count == 0) begin
            $display("PASS rangefinder_average_tilt_correct");
        end else begin
            $display("FAIL rangefinder_average_tilt_correct");
        end
        $finish;
    end

endmodule
